FILE: rtl/core/dhtdr_pkg.sv
package dhtdr_pkg;

	localparam int ENTRIES     = 64;
	localparam int KEY_BITS    = 16;
	localparam int IDX_BITS    = $clog2(ENTRIES);
	localparam int CNT_BITS    = $clog2(ENTRIES + 1);
	localparam int MAX_RESULTS = 32;
	localparam int NUM_BITS    = $clog2(MAX_RESULTS);

	// command codes
	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_INDEX  = 3'd2;
	localparam logic [2:0] MODE_KEY    = 3'd3;
	localparam logic [2:0] MODE_UPDATE = 3'd4;

	// status codes
	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_MISSING  = 3'd1;
	localparam logic [2:0] STAT_DUP      = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_BAD_SLOT = 3'd4;

	typedef struct packed {
		logic [2:0]          mode;
		logic [KEY_BITS-1:0] key;
		logic [5:0]          slot;
	} cmd_t;

	typedef struct packed {
		logic [2:0]          status;
		logic                found;
		logic [5:0]          position;
		logic [KEY_BITS-1:0] entry_key;
		logic [5:0]          range_begin;
		logic [6:0]          range_end;
		logic [6:0]          capacity;
		logic [6:0]          entry_count;
		logic                last;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_MOVE,
		S_RDSLOT,
		S_SHRINK,
		S_GROW,
		S_DSCAN,
		S_FINAL,
		S_EMIT
	} state_t;

endpackage

FILE: rtl/core/dense_handle_table_dirty_ranges_core.sv
// Dense handle table with swap-remove and coalesced dirty-range reporting.
// Command channel: cmd_valid / cmd_stall / cmd carries mode, key and slot.
// Result channel: res_valid / res_stall / res carries one result beat.
// One command is worked at a time; cmd_stall is high while it is in flight.
// Add, remove and index-of-key scan the key memory one slot per cycle,
// pipelined through its registered read.
// Key-at-index reads one slot. Update steps the capacity one
// halving or doubling per cycle, then walks all 64 dirty marks
// one per cycle unless held for the receiver, giving up to 32 beats.
// The last beat of each command has last set.
// Results sit in an output register; a new command can be taken while
// the final beat of the previous one waits there.
// When the receiver stalls, the dirty walk pauses at a slot that must
// close a range until the register frees.
// Reset clears count, capacity and dirty marks; key memory is not cleared,
// only the data of filled slots is ever used.
module dense_handle_table_dirty_ranges_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  dhtdr_pkg::cmd_t   cmd,
	output logic              res_valid,
	input  logic              res_stall,
	output dhtdr_pkg::res_t   res
);

	localparam int IB = dhtdr_pkg::IDX_BITS;
	localparam int CB = dhtdr_pkg::CNT_BITS;
	localparam int KB = dhtdr_pkg::KEY_BITS;
	localparam int NB = dhtdr_pkg::NUM_BITS;

	dhtdr_pkg::state_t state_q, state_nx;
	dhtdr_pkg::cmd_t   cmd_q;
	dhtdr_pkg::res_t   res_q, res_nx, rs_q;
	logic              res_valid_q;

	logic [CB-1:0]                used_q, cap_q, cnt_q, e_q;
	logic [IB-1:0]                b_q, w_q, idx_s1;
	logic                         pend_s1, open_q;
	logic [NB-1:0]                n_q;
	logic [dhtdr_pkg::ENTRIES-1:0] dirty_q;

	logic          accept, out_free, res_load;
	logic          mem_we;
	logic [IB-1:0] mem_waddr, mem_raddr;
	logic [KB-1:0] mem_wdata, mem_rdata;
	logic          rd_en, match, miss;
	logic [CB-1:0] top;
	logic          d_hit, need_emit, scan_hold, scan_done;
	logic          bad_slot;

	dhtdr_key_mem u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != dhtdr_pkg::S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign top       = used_q - CB'(1);

	// key scan, dirty walk and bad-slot decode
	always_comb begin
		match     = (state_q == dhtdr_pkg::S_SCAN) && pend_s1 && (mem_rdata == cmd_q.key);
		rd_en     = (cnt_q < used_q) && !match;
		miss      = (state_q == dhtdr_pkg::S_SCAN) && !pend_s1 && (cnt_q >= used_q);
		d_hit     = dirty_q[cnt_q[IB-1:0]] && (cnt_q < used_q);
		need_emit = d_hit && open_q && (cnt_q != e_q) && (n_q != NB'(dhtdr_pkg::MAX_RESULTS - 1));
		scan_hold = need_emit && !out_free;
		scan_done = (cnt_q[IB-1:0] == IB'(dhtdr_pkg::ENTRIES - 1));
		bad_slot  = (cmd.mode == dhtdr_pkg::MODE_KEY) && !({1'b0, cmd.slot} < used_q);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dhtdr_pkg::S_IDLE: begin
				if (accept) begin
					case (cmd.mode)
						dhtdr_pkg::MODE_ADD, dhtdr_pkg::MODE_REMOVE,
						dhtdr_pkg::MODE_INDEX: state_nx = dhtdr_pkg::S_SCAN;
						dhtdr_pkg::MODE_KEY: begin
							state_nx = ({1'b0, cmd.slot} < used_q) ?
								dhtdr_pkg::S_RDSLOT : dhtdr_pkg::S_EMIT;
						end
						dhtdr_pkg::MODE_UPDATE: begin
							state_nx = ((cap_q >> 2) > used_q) ?
								dhtdr_pkg::S_SHRINK : dhtdr_pkg::S_GROW;
						end
						default: state_nx = dhtdr_pkg::S_EMIT;
					endcase
				end
			end
			dhtdr_pkg::S_SCAN: begin
				if (match && cmd_q.mode == dhtdr_pkg::MODE_REMOVE &&
				    {1'b0, idx_s1} != top) begin
					state_nx = dhtdr_pkg::S_MOVE;
				end else if (match || miss) begin
					state_nx = dhtdr_pkg::S_EMIT;
				end
			end
			dhtdr_pkg::S_MOVE:   state_nx = dhtdr_pkg::S_EMIT;
			dhtdr_pkg::S_RDSLOT: state_nx = dhtdr_pkg::S_EMIT;
			dhtdr_pkg::S_SHRINK: begin
				if (!((cap_q >> 2) > used_q)) state_nx = dhtdr_pkg::S_DSCAN;
			end
			dhtdr_pkg::S_GROW: begin
				if (!(used_q > cap_q)) state_nx = dhtdr_pkg::S_DSCAN;
			end
			dhtdr_pkg::S_DSCAN: begin
				if (!scan_hold && scan_done) state_nx = dhtdr_pkg::S_FINAL;
			end
			dhtdr_pkg::S_FINAL, dhtdr_pkg::S_EMIT: begin
				if (out_free) state_nx = dhtdr_pkg::S_IDLE;
			end
			default: state_nx = dhtdr_pkg::S_IDLE;
		endcase
	end

	// memory controls and result beat selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = used_q[IB-1:0];
		mem_wdata = cmd_q.key;
		mem_raddr = cnt_q[IB-1:0];
		res_load  = 1'b0;
		res_nx    = rs_q;
		res_nx.capacity    = cap_q;
		res_nx.entry_count = used_q;
		res_nx.last        = 1'b1;
		case (state_q)
			dhtdr_pkg::S_IDLE: begin
				mem_raddr = cmd.slot[IB-1:0];
			end
			dhtdr_pkg::S_SCAN: begin
				if (match && cmd_q.mode == dhtdr_pkg::MODE_REMOVE) begin
					mem_raddr = top[IB-1:0];
				end
				if (miss && cmd_q.mode == dhtdr_pkg::MODE_ADD &&
				    used_q != CB'(dhtdr_pkg::ENTRIES)) begin
					mem_we = 1'b1;
				end
			end
			dhtdr_pkg::S_MOVE: begin
				mem_we    = 1'b1;
				mem_waddr = w_q;
				mem_wdata = mem_rdata;
			end
			dhtdr_pkg::S_DSCAN: begin
				if (need_emit && out_free) begin
					res_load           = 1'b1;
					res_nx             = '0;
					res_nx.range_begin = b_q;
					res_nx.range_end   = e_q;
					res_nx.capacity    = cap_q;
					res_nx.entry_count = used_q;
				end
			end
			dhtdr_pkg::S_FINAL: begin
				res_load           = out_free;
				res_nx             = '0;
				res_nx.range_begin = open_q ? b_q : '0;
				res_nx.range_end   = open_q ? e_q : '0;
				res_nx.capacity    = cap_q;
				res_nx.entry_count = used_q;
				res_nx.last        = 1'b1;
			end
			dhtdr_pkg::S_EMIT: begin
				res_load = out_free;
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dhtdr_pkg::S_IDLE;
			res_valid_q <= 1'b0;
			used_q      <= '0;
			cap_q       <= '0;
			dirty_q     <= '0;
			pend_s1     <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			pend_s1 <= (state_q == dhtdr_pkg::S_SCAN) && rd_en;
			case (state_q)
				dhtdr_pkg::S_SCAN: begin
					if (mem_we) begin
						dirty_q[used_q[IB-1:0]] <= 1'b1;
						used_q                  <= used_q + CB'(1);
					end
					if (match && cmd_q.mode == dhtdr_pkg::MODE_REMOVE &&
					    {1'b0, idx_s1} == top) begin
						dirty_q[top[IB-1:0]] <= 1'b0;
						used_q               <= top;
					end
				end
				dhtdr_pkg::S_MOVE: begin
					dirty_q[w_q]         <= 1'b1;
					dirty_q[top[IB-1:0]] <= 1'b0;
					used_q               <= top;
				end
				dhtdr_pkg::S_SHRINK: begin
					if ((cap_q >> 2) > used_q) cap_q <= cap_q >> 1;
				end
				dhtdr_pkg::S_GROW: begin
					if (used_q > cap_q) cap_q <= (cap_q == '0) ? CB'(1) : (cap_q << 1);
				end
				dhtdr_pkg::S_FINAL: begin
					if (out_free) dirty_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_nx;
	end

	// command payload, scan counters and staged result fields
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IB-1:0];
		case (state_q)
			dhtdr_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q  <= cmd;
					cnt_q  <= '0;
					open_q <= 1'b0;
					n_q    <= '0;
					// a slot past the filled part answers with a bad-slot status
					rs_q   <= '{status: bad_slot ? dhtdr_pkg::STAT_BAD_SLOT : dhtdr_pkg::STAT_OK,
						default: '0};
				end
			end
			dhtdr_pkg::S_SCAN: begin
				if (rd_en) cnt_q <= cnt_q + CB'(1);
				if (match) begin
					w_q      <= idx_s1;
					rs_q.found <= 1'b1;
					case (cmd_q.mode)
						dhtdr_pkg::MODE_ADD: begin
							rs_q.status   <= dhtdr_pkg::STAT_DUP;
							rs_q.position <= 6'(idx_s1);
						end
						dhtdr_pkg::MODE_INDEX: rs_q.position <= 6'(idx_s1);
						default: ;
					endcase
				end else if (miss) begin
					if (cmd_q.mode == dhtdr_pkg::MODE_ADD) begin
						if (used_q == CB'(dhtdr_pkg::ENTRIES)) begin
							rs_q.status <= dhtdr_pkg::STAT_FULL;
						end else begin
							rs_q.found    <= 1'b1;
							rs_q.position <= 6'(used_q[IB-1:0]);
						end
					end else begin
						rs_q.status <= dhtdr_pkg::STAT_MISSING;
					end
				end
			end
			dhtdr_pkg::S_RDSLOT: begin
				rs_q.found     <= 1'b1;
				rs_q.entry_key <= mem_rdata;
			end
			dhtdr_pkg::S_DSCAN: begin
				if (!scan_hold) begin
					cnt_q <= cnt_q + CB'(1);
					if (d_hit) begin
						e_q <= cnt_q + CB'(1);
						if (!open_q) begin
							open_q <= 1'b1;
							b_q    <= cnt_q[IB-1:0];
						end else if (need_emit) begin
							b_q <= cnt_q[IB-1:0];
							n_q <= n_q + NB'(1);
						end
					end
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/dhtdr_key_mem.sv
module dhtdr_key_mem (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [dhtdr_pkg::IDX_BITS-1:0]       waddr,
	input  logic [dhtdr_pkg::KEY_BITS-1:0]       wdata,
	input  logic [dhtdr_pkg::IDX_BITS-1:0]       raddr,
	output logic [dhtdr_pkg::KEY_BITS-1:0]       rdata
);

	logic [dhtdr_pkg::KEY_BITS-1:0] mem_q [dhtdr_pkg::ENTRIES];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: tb/testbench.sv
// Scoreboard: mirrors the handle table and queues expected result beats.
class table_scoreboard;
	logic [15:0] keys [64];
	bit          dirty [64];
	int unsigned count;
	int unsigned cap;
	dhtdr_pkg::res_t pending [$];
	int errors;

	function new();
		count = 0;
		cap = 0;
		errors = 0;
		foreach (dirty[i]) dirty[i] = 0;
	endfunction

	function int find_slot(logic [15:0] k);
		for (int i = 0; i < count; i++)
			if (keys[i] == k) return i;
		return -1;
	endfunction

	function void add_beat(logic [2:0] st, bit fnd, int pos, logic [15:0] ek,
			int rb, int re, bit lst);
		dhtdr_pkg::res_t r;
		r.status = st;
		r.found = fnd;
		r.position = pos[5:0];
		r.entry_key = ek;
		r.range_begin = rb[5:0];
		r.range_end = re[6:0];
		r.capacity = cap[6:0];
		r.entry_count = count[6:0];
		r.last = lst;
		pending.insert(pending.size(), r);
	endfunction

	// note an accepted command and predict its beats
	function void note_cmd(dhtdr_pkg::cmd_t c);
		int w;
		int n;
		int b;
		int e;
		bit open;
		w = find_slot(c.key);
		case (c.mode)
			dhtdr_pkg::MODE_ADD: begin
				if (w >= 0) add_beat(dhtdr_pkg::STAT_DUP, 1, w, 0, 0, 0, 1);
				else if (count >= 64) add_beat(dhtdr_pkg::STAT_FULL, 0, 0, 0, 0, 0, 1);
				else begin
					w = count;
					keys[w] = c.key;
					dirty[w] = 1;
					count++;
					add_beat(dhtdr_pkg::STAT_OK, 1, w, 0, 0, 0, 1);
				end
			end
			dhtdr_pkg::MODE_REMOVE: begin
				if (w < 0) add_beat(dhtdr_pkg::STAT_MISSING, 0, 0, 0, 0, 0, 1);
				else begin
					if (w != count - 1) begin
						keys[w] = keys[count-1];
						dirty[w] = 1;
					end
					dirty[count-1] = 0;
					count--;
					add_beat(dhtdr_pkg::STAT_OK, 1, 0, 0, 0, 0, 1);
				end
			end
			dhtdr_pkg::MODE_INDEX: begin
				if (w >= 0) add_beat(dhtdr_pkg::STAT_OK, 1, w, 0, 0, 0, 1);
				else add_beat(dhtdr_pkg::STAT_MISSING, 0, 0, 0, 0, 0, 1);
			end
			dhtdr_pkg::MODE_KEY: begin
				if (c.slot < count) add_beat(dhtdr_pkg::STAT_OK, 1, 0, keys[c.slot], 0, 0, 1);
				else add_beat(dhtdr_pkg::STAT_BAD_SLOT, 0, 0, 0, 0, 0, 1);
			end
			dhtdr_pkg::MODE_UPDATE: begin
				// resize policy, then coalesce dirty slots into ranges
				if (cap / 4 > count) begin
					while (cap / 4 > count) cap = cap / 2;
				end else begin
					while (count > cap) cap = (cap == 0) ? 1 : cap * 2;
				end
				n = 0;
				b = 0;
				e = 0;
				open = 0;
				for (int i = 0; i < 64; i++) begin
					if (!dirty[i] || i >= count) continue;
					if (open && i == e) e = i + 1;
					else if (open && n < 31) begin
						add_beat(dhtdr_pkg::STAT_OK, 0, 0, 0, b, e, 0);
						n++;
						b = i;
						e = i + 1;
					end else if (open) e = i + 1;
					else begin
						open = 1;
						b = i;
						e = i + 1;
					end
				end
				add_beat(dhtdr_pkg::STAT_OK, 0, 0, 0, open ? b : 0, open ? e : 0, 1);
				foreach (dirty[i]) dirty[i] = 0;
			end
			default: add_beat(dhtdr_pkg::STAT_OK, 0, 0, 0, 0, 0, 1);
		endcase
	endfunction

	// compare one result beat with the oldest expectation
	function void check_beat(dhtdr_pkg::res_t got);
		dhtdr_pkg::res_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected beat, expected none, actual %h", $time, got);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		if (got !== exp_r) begin
			$display("%0t: beat differs, expected %h, actual %h", $time, exp_r, got);
			if (got.status !== exp_r.status)
				$display("%0t:  status expected %0d actual %0d", $time, exp_r.status, got.status);
			if (got.found !== exp_r.found)
				$display("%0t:  found expected %0d actual %0d", $time, exp_r.found, got.found);
			if (got.position !== exp_r.position)
				$display("%0t:  position expected %0d actual %0d", $time, exp_r.position,
					got.position);
			if (got.entry_key !== exp_r.entry_key)
				$display("%0t:  entry_key expected %h actual %h", $time, exp_r.entry_key,
					got.entry_key);
			if (got.range_begin !== exp_r.range_begin || got.range_end !== exp_r.range_end)
				$display("%0t:  range expected %0d..%0d actual %0d..%0d", $time,
					exp_r.range_begin, exp_r.range_end, got.range_begin, got.range_end);
			if (got.capacity !== exp_r.capacity || got.entry_count !== exp_r.entry_count)
				$display("%0t:  cap/count expected %0d/%0d actual %0d/%0d", $time,
					exp_r.capacity, exp_r.entry_count, got.capacity, got.entry_count);
			if (got.last !== exp_r.last)
				$display("%0t:  last expected %0d actual %0d", $time, exp_r.last, got.last);
			errors++;
		end
	endfunction
endclass

module testbench;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	dhtdr_pkg::cmd_t cmd;
	logic res_valid;
	logic res_stall;
	dhtdr_pkg::res_t res;

	table_scoreboard sb;
	logic [15:0] key_pool [8];

	dense_handle_table_dirty_ranges_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("dense_handle_table_dirty_ranges_core: mismatch");
		$finish;
	end

	// send one command beat after a random gap; valid stays up until the
	// next gap or drain, the block holds stall while the beat is worked
	task automatic send_cmd(logic [2:0] m, logic [15:0] k, logic [5:0] s);
		int gap;
		bit taken;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{mode: m, key: k, slot: s};
		// stall is settled at the falling edge before the accepting edge
		do begin
			@(negedge clk);
			taken = !cmd_stall;
			@(posedge clk);
		end while (!taken);
		sb.note_cmd(cmd);
	endtask

	task automatic wait_drain();
		cmd_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_key();
		if ($urandom_range(0, 3) == 0) return 16'($urandom);
		return key_pool[$urandom_range(0, 7)];
	endfunction

	// receiver: random stalls, with calm stretches
	initial begin
		int hold;
		bit fire;
		dhtdr_pkg::res_t beat;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			fire = res_valid && !res_stall;
			beat = res;
			@(posedge clk);
			if (fire) sb.check_beat(beat);
			if (hold > 0) begin
				hold--;
			end else if (fire) begin
				hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
				res_stall <= (hold != 0);
			end else if (res_stall) begin
				res_stall <= 1'b0;
			end
		end
	end

	initial begin
		int r;
		sb = new();
		foreach (key_pool[i]) key_pool[i] = 16'($urandom);
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;
		arst_n = 0;
		cmd_valid = 0;
		cmd = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty update, bad slot, misses, extremes, duplicates, unused modes
		send_cmd(dhtdr_pkg::MODE_UPDATE, 0, 0);
		send_cmd(dhtdr_pkg::MODE_KEY, 0, 0);
		send_cmd(dhtdr_pkg::MODE_REMOVE, 16'h1234, 0);
		send_cmd(dhtdr_pkg::MODE_INDEX, 16'hFFFF, 0);
		send_cmd(dhtdr_pkg::MODE_ADD, 16'h0000, 0);
		send_cmd(dhtdr_pkg::MODE_ADD, 16'hFFFF, 0);
		send_cmd(dhtdr_pkg::MODE_ADD, 16'hFFFF, 0);
		send_cmd(dhtdr_pkg::MODE_ADD, 16'h5A5A, 0);
		send_cmd(dhtdr_pkg::MODE_INDEX, 16'hFFFF, 0);
		send_cmd(dhtdr_pkg::MODE_KEY, 0, 6'd1);
		send_cmd(dhtdr_pkg::MODE_KEY, 0, 6'd63);
		send_cmd(dhtdr_pkg::MODE_REMOVE, 16'h5A5A, 0);
		send_cmd(dhtdr_pkg::MODE_REMOVE, 16'h0000, 0);
		send_cmd(3'd5, 16'hAAAA, 6'h2A);
		send_cmd(3'd7, 16'h5555, 6'h15);
		send_cmd(dhtdr_pkg::MODE_UPDATE, 0, 0);
		wait_drain();

		// random: mostly pooled keys so hits and removes happen
		for (int n = 0; n < 20; n++) begin
			r = $urandom_range(0, 99);
			if (r < 35) send_cmd(dhtdr_pkg::MODE_ADD, pick_key(), 0);
			else if (r < 55) send_cmd(dhtdr_pkg::MODE_REMOVE, pick_key(), 0);
			else if (r < 67) send_cmd(dhtdr_pkg::MODE_INDEX, pick_key(), 0);
			else if (r < 80) send_cmd(dhtdr_pkg::MODE_KEY, 0, 6'($urandom));
			else if (r < 95) send_cmd(dhtdr_pkg::MODE_UPDATE, 0, 0);
			else send_cmd(3'($urandom_range(5, 7)), 16'($urandom), 6'($urandom));
			if (n == 10) wait_drain();
		end

		// fill to full, check the full status and a large update
		for (int i = 0; i < 64; i++) send_cmd(dhtdr_pkg::MODE_ADD, 16'(i * 977 + 3), 0);
		send_cmd(dhtdr_pkg::MODE_ADD, 16'hBEEF, 0);
		send_cmd(dhtdr_pkg::MODE_KEY, 0, 6'd63);
		send_cmd(dhtdr_pkg::MODE_UPDATE, 0, 0);

		wait_drain();
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("dense_handle_table_dirty_ranges_core: match");
		else
			$display("dense_handle_table_dirty_ranges_core: mismatch");
		$finish;
	end
endmodule

FILE: files.f
rtl/core/dhtdr_pkg.sv
rtl/core/dhtdr_key_mem.sv
rtl/core/dense_handle_table_dirty_ranges_core.sv
tb/testbench.sv
